/* design/text_console_cursor_engine_top_macros.svh */
// assertion macros shared by the console checker
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TCCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TCCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tcce_pkg.sv */
// shared types, constants and codes of the text console cursor engine
`timescale 1ns / 1ps
package tcce_pkg;

  localparam int COLUMNS_DEF      = 80;
  localparam int ROWS_DEF         = 25;
  localparam int BUFFER_CELLS_DEF = 16384;

  localparam int REQ_TYPE_W = 2;
  localparam int CHAR_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CELL_IDX_W = 14;
  localparam int DATA_W     = 16;
  localparam int TOP_W      = 8;
  localparam int ATTR_W     = 8;
  localparam int ADDR_OUT_W = 14;
  // widest cell index any cursor or sweep sum reaches over the parameter ranges
  localparam int FULL_ADDR_W = 16;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam int REG_IDX_W  = PADDR_W - 2;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_CLEAR   = 8'h07;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_PUT     = 2'd0,
    REQ_SET_POS = 2'd1,
    REQ_READ    = 2'd2
  } req_type_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TEXT_ATTR = 1'b0
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_CLEAR,
    ST_ADDR,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic latch_req;
    logic set_acc;
    logic wr_char;
    logic new_line;
    logic set_pos;
    logic rd_cell;
    logic scroll_start;
    logic copy_rd;
    logic copy_wr;
    logic clear_wr;
    logic calc_addr;
    logic load_rsp;
  } cmd_t;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic                  is_newline;
    logic                  col_last;
    logic                  row_last;
    logic                  scroll_fits;
    logic                  copy_last;
    logic                  clear_last;
    logic                  rsp_free;
  } sts_t;

endpackage

/* design/tcce_req_if.sv */
// request channel: valid/ready handshake with the request fields
`timescale 1ns / 1ps
interface tcce_req_if;
  logic                              valid;
  logic                              ready;
  logic [tcce_pkg::REQ_TYPE_W-1:0]   req_type;
  logic [tcce_pkg::CHAR_W-1:0]       char_code;
  logic [tcce_pkg::COL_W-1:0]        target_column;
  logic [tcce_pkg::ROW_W-1:0]        target_row;
  logic [tcce_pkg::CELL_IDX_W-1:0]   cell_index;

  modport source (
    output valid, req_type, char_code, target_column, target_row, cell_index,
    input  ready
  );
  modport sink (
    input  valid, req_type, char_code, target_column, target_row, cell_index,
    output ready
  );
endinterface

/* design/tcce_rsp_if.sv */
// response channel: valid/ready handshake with the result fields
`timescale 1ns / 1ps
interface tcce_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic [tcce_pkg::ADDR_OUT_W-1:0]   cursor_address;
  logic [tcce_pkg::ADDR_OUT_W-1:0]   start_address;
  logic [tcce_pkg::DATA_W-1:0]       read_data;

  modport source (
    output valid, accepted, cursor_address, start_address, read_data,
    input  ready
  );
  modport sink (
    input  valid, accepted, cursor_address, start_address, read_data,
    output ready
  );
endinterface

/* design/text_console_cursor_engine_top.sv */
// Text console cursor engine: character-cell console owning its text buffer.
// Requests arrive on req_i (valid/ready); one response beat per request
// leaves on rsp_o. A put request writes the attribute and character at the
// cursor and advances it, a set request moves the cursor inside the window,
// a read request returns one buffer cell. The attribute register sits on
// the APB port at byte address 0; the user must write it only while the
// block idles, and the block itself does not enforce this. One request is
// worked on at a time. Put and set requests pass the execute, address and
// finish states before the next request can be taken, reads skip the
// address state. A newline or wrap past the bottom row scrolls, clearing
// the new bottom row; at the end of the buffer the visible rows are copied
// to the buffer start first. req_i.ready stays low meanwhile.
// The response waits in an output register; a stalled receiver holds it and
// the next request is still taken, its result held until the register frees.
// Reset clears the cursor, window top and handshake state; the attribute
// returns to 7. Buffer contents are unknown until written.
`timescale 1ns / 1ps
module text_console_cursor_engine_top #(
  parameter int COLUMNS      = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS         = tcce_pkg::ROWS_DEF,
  parameter int BUFFER_CELLS = tcce_pkg::BUFFER_CELLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tcce_req_if.sink                          req_i,
  tcce_rsp_if.source                        rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcce_pkg::PADDR_W-1:0]      paddr,
  input  logic [tcce_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tcce_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  tcce_pkg::cmd_t              cmd;
  tcce_pkg::sts_t              sts;
  logic [tcce_pkg::ATTR_W-1:0] attr;

  tcce_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .attr_o  (attr)
  );

  tcce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcce_datapath #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .BUFFER_CELLS (BUFFER_CELLS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .attr_i           (attr),
    .req_type_i       (req_i.req_type),
    .char_code_i      (req_i.char_code),
    .target_column_i  (req_i.target_column),
    .target_row_i     (req_i.target_row),
    .cell_index_i     (req_i.cell_index),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_valid_o      (rsp_o.valid),
    .accepted_o       (rsp_o.accepted),
    .cursor_address_o (rsp_o.cursor_address),
    .start_address_o  (rsp_o.start_address),
    .read_data_o      (rsp_o.read_data)
  );

endmodule

/* design/tcce_cfg_regs.sv */
// apb register block holding the text attribute
`timescale 1ns / 1ps
module tcce_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcce_pkg::PADDR_W-1:0]      paddr,
  input  logic [tcce_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [tcce_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [tcce_pkg::ATTR_W-1:0]       attr_o
);

  logic [tcce_pkg::ATTR_W-1:0]    attr_q;
  logic [tcce_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[tcce_pkg::PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcce_pkg::ATTR_RESET;
    end else if (wr_en && (reg_idx == tcce_pkg::REG_TEXT_ATTR)) begin
      attr_q <= pwdata[tcce_pkg::ATTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == tcce_pkg::REG_TEXT_ATTR) begin
      prdata = {{(tcce_pkg::APB_DATA_W-tcce_pkg::ATTR_W){1'b0}}, attr_q};
    end
  end

  assign attr_o = attr_q;

endmodule

/* design/tcce_ctrl.sv */
// sequencing state machine: request decode, scroll sweeps, response hand-off
`timescale 1ns / 1ps
module tcce_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  tcce_pkg::sts_t  sts_i,
  output tcce_pkg::cmd_t  cmd_o
);

  tcce_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcce_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      tcce_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_req = 1'b1;
          state_d         = tcce_pkg::ST_EXEC;
        end
      end
      tcce_pkg::ST_EXEC: begin
        cmd_o.set_acc = 1'b1;
        unique case (sts_i.req_type)
          tcce_pkg::REQ_PUT: begin
            if (sts_i.is_newline) begin
              if (sts_i.row_last) begin
                state_d = tcce_pkg::ST_SCROLL;
              end else begin
                cmd_o.new_line = 1'b1;
                state_d        = tcce_pkg::ST_ADDR;
              end
            end else begin
              cmd_o.wr_char = 1'b1;
              if (sts_i.col_last && sts_i.row_last) begin
                state_d = tcce_pkg::ST_SCROLL;
              end else begin
                // wrap on the last column
                cmd_o.new_line = sts_i.col_last;
                state_d        = tcce_pkg::ST_ADDR;
              end
            end
          end
          tcce_pkg::REQ_SET_POS: begin
            cmd_o.set_pos = 1'b1;
            state_d       = tcce_pkg::ST_ADDR;
          end
          tcce_pkg::REQ_READ: begin
            cmd_o.rd_cell = 1'b1;
            state_d       = tcce_pkg::ST_FINISH;
          end
          default: begin
            state_d = tcce_pkg::ST_FINISH;
          end
        endcase
      end
      tcce_pkg::ST_SCROLL: begin
        cmd_o.scroll_start = 1'b1;
        state_d = sts_i.scroll_fits ? tcce_pkg::ST_CLEAR : tcce_pkg::ST_COPY_RD;
      end
      tcce_pkg::ST_COPY_RD: begin
        cmd_o.copy_rd = 1'b1;
        state_d       = tcce_pkg::ST_COPY_WR;
      end
      tcce_pkg::ST_COPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        state_d = sts_i.copy_last ? tcce_pkg::ST_CLEAR : tcce_pkg::ST_COPY_RD;
      end
      tcce_pkg::ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = tcce_pkg::ST_ADDR;
        end
      end
      tcce_pkg::ST_ADDR: begin
        cmd_o.calc_addr = 1'b1;
        state_d         = tcce_pkg::ST_FINISH;
      end
      tcce_pkg::ST_FINISH: begin
        if (sts_i.rsp_free) begin
          cmd_o.load_rsp = 1'b1;
          state_d        = tcce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcce_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/tcce_datapath.sv */
// cursor registers, text buffer memory, sweep counter and response register
`timescale 1ns / 1ps
module tcce_datapath #(
  parameter int COLUMNS      = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS         = tcce_pkg::ROWS_DEF,
  parameter int BUFFER_CELLS = tcce_pkg::BUFFER_CELLS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tcce_pkg::cmd_t                    cmd_i,
  output tcce_pkg::sts_t                    sts_o,
  input  logic [tcce_pkg::ATTR_W-1:0]       attr_i,
  input  logic [tcce_pkg::REQ_TYPE_W-1:0]   req_type_i,
  input  logic [tcce_pkg::CHAR_W-1:0]       char_code_i,
  input  logic [tcce_pkg::COL_W-1:0]        target_column_i,
  input  logic [tcce_pkg::ROW_W-1:0]        target_row_i,
  input  logic [tcce_pkg::CELL_IDX_W-1:0]   cell_index_i,
  input  logic                              rsp_ready_i,
  output logic                              rsp_valid_o,
  output logic                              accepted_o,
  output logic [tcce_pkg::ADDR_OUT_W-1:0]   cursor_address_o,
  output logic [tcce_pkg::ADDR_OUT_W-1:0]   start_address_o,
  output logic [tcce_pkg::DATA_W-1:0]       read_data_o
);

  localparam int Fw         = tcce_pkg::FULL_ADDR_W;
  localparam int MemAw      = $clog2(BUFFER_CELLS);
  localparam int CopyCells  = (ROWS - 1) * COLUMNS;
  localparam int CntW       = $clog2(CopyCells);
  localparam int LastRowOff = (ROWS - 1) * COLUMNS;
  localparam int WinCells   = ROWS * COLUMNS;

  // latched request
  logic [tcce_pkg::REQ_TYPE_W-1:0] req_type_q;
  logic [tcce_pkg::CHAR_W-1:0]     char_q;
  logic [tcce_pkg::COL_W-1:0]      tcol_q;
  logic [tcce_pkg::ROW_W-1:0]      trow_q;
  logic [tcce_pkg::CELL_IDX_W-1:0] cidx_q;

  // cursor and window state
  logic [tcce_pkg::COL_W-1:0] col_q, col_d;
  logic [tcce_pkg::ROW_W-1:0] row_q, row_d;
  logic [tcce_pkg::TOP_W-1:0] top_q;
  logic [Fw-1:0]              start_q;
  logic [Fw-1:0]              cur_q;
  logic                       acc_q;
  logic                       fits_q;
  logic [Fw-1:0]              sweep_base_q;
  logic [CntW-1:0]            cnt_q;

  // text buffer
  logic [tcce_pkg::DATA_W-1:0] mem_q [BUFFER_CELLS];
  logic [tcce_pkg::DATA_W-1:0] rd_q;
  logic                        mem_we;
  logic [Fw-1:0]               mem_waddr;
  logic [tcce_pkg::DATA_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [MemAw-1:0]            mem_raddr;

  // response register
  logic                              rsp_valid_q;
  logic                              rsp_acc_q;
  logic [tcce_pkg::ADDR_OUT_W-1:0]   rsp_cur_q;
  logic [tcce_pkg::ADDR_OUT_W-1:0]   rsp_start_q;
  logic [tcce_pkg::DATA_W-1:0]       rsp_data_q;

  logic [tcce_pkg::CHAR_W-1:0] char_eff;
  logic                        pos_ok;
  logic                        rd_ok;
  logic                        acc_calc;
  logic [Fw-1:0]               top_base;
  logic                        scroll_fits;
  logic [Fw-1:0]               sweep_addr;
  logic [Fw-1:0]               cnt_full;
  logic                        copy_last;
  logic                        clear_last;
  logic [tcce_pkg::TOP_W:0]    row_abs;

  assign char_eff    = (char_q == tcce_pkg::CHAR_TAB) ? tcce_pkg::CHAR_SPACE : char_q;
  assign pos_ok      = (tcol_q < tcce_pkg::COL_W'(COLUMNS)) &&
                       (trow_q < tcce_pkg::ROW_W'(ROWS));
  assign rd_ok       = Fw'(cidx_q) < Fw'(BUFFER_CELLS);
  // window top after a scroll, as a cell index
  assign top_base    = start_q + Fw'(COLUMNS);
  assign scroll_fits = (top_base + Fw'(WinCells)) <= Fw'(BUFFER_CELLS);
  assign cnt_full    = Fw'(cnt_q);
  assign sweep_addr  = sweep_base_q + cnt_full;
  assign copy_last   = cnt_q == CntW'(CopyCells - 1);
  assign clear_last  = cnt_q == CntW'(COLUMNS - 1);
  assign row_abs     = {{(tcce_pkg::TOP_W+1-tcce_pkg::ROW_W){1'b0}}, row_q} +
                       {1'b0, top_q};

  always_comb begin
    unique case (req_type_q)
      tcce_pkg::REQ_PUT:     acc_calc = 1'b1;
      tcce_pkg::REQ_SET_POS: acc_calc = pos_ok;
      tcce_pkg::REQ_READ:    acc_calc = rd_ok;
      default:               acc_calc = 1'b0;
    endcase
  end

  always_comb begin
    sts_o.req_type    = req_type_q;
    sts_o.is_newline  = char_q == tcce_pkg::CHAR_NEWLINE;
    sts_o.col_last    = col_q == tcce_pkg::COL_W'(COLUMNS - 1);
    sts_o.row_last    = row_q == tcce_pkg::ROW_W'(ROWS - 1);
    sts_o.scroll_fits = scroll_fits;
    sts_o.copy_last   = copy_last;
    sts_o.clear_last  = clear_last;
    sts_o.rsp_free    = !rsp_valid_q || rsp_ready_i;
  end

  // buffer write and read port selection; writes outside the buffer are dropped
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = {attr_i, char_eff};
    if (cmd_i.wr_char) begin
      mem_we = cur_q < Fw'(BUFFER_CELLS);
    end else if (cmd_i.copy_wr) begin
      mem_we    = (sweep_addr < Fw'(BUFFER_CELLS)) && (cnt_full < Fw'(BUFFER_CELLS));
      mem_waddr = cnt_full;
      mem_wdata = rd_q;
    end else if (cmd_i.clear_wr) begin
      mem_we    = sweep_addr < Fw'(BUFFER_CELLS);
      mem_waddr = sweep_addr;
      mem_wdata = {tcce_pkg::ATTR_CLEAR, tcce_pkg::CHAR_SPACE};
    end
    mem_re    = cmd_i.rd_cell || cmd_i.copy_rd;
    mem_raddr = cmd_i.copy_rd ? sweep_addr[MemAw-1:0] : cidx_q[MemAw-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr[MemAw-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.scroll_start) begin
      col_d = '0;
      row_d = tcce_pkg::ROW_W'(ROWS - 1);
    end else if (cmd_i.new_line) begin
      col_d = '0;
      row_d = row_q + 1'b1;
    end else if (cmd_i.wr_char) begin
      col_d = col_q + 1'b1;
    end else if (cmd_i.set_pos && pos_ok) begin
      col_d = tcol_q;
      row_d = trow_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      req_type_q <= req_type_i;
      char_q     <= char_code_i;
      tcol_q     <= target_column_i;
      trow_q     <= target_row_i;
      cidx_q     <= cell_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      top_q        <= '0;
      start_q      <= '0;
      cur_q        <= '0;
      acc_q        <= 1'b0;
      fits_q       <= 1'b0;
      sweep_base_q <= '0;
      cnt_q        <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.set_acc) begin
        acc_q <= acc_calc;
      end
      if (cmd_i.scroll_start) begin
        fits_q       <= scroll_fits;
        sweep_base_q <= scroll_fits ? top_base + Fw'(LastRowOff) : top_base;
        cnt_q        <= '0;
      end
      if (cmd_i.copy_wr) begin
        if (copy_last) begin
          // copy done, clear the bottom row of the rebased window
          cnt_q        <= '0;
          sweep_base_q <= Fw'(LastRowOff);
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.clear_wr) begin
        if (clear_last) begin
          cnt_q <= '0;
          top_q <= fits_q ? top_q + 1'b1 : '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (cmd_i.calc_addr) begin
        start_q <= Fw'(top_q) * Fw'(COLUMNS);
        cur_q   <= Fw'(row_abs) * Fw'(COLUMNS) + Fw'(col_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.load_rsp) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_rsp) begin
      rsp_acc_q   <= acc_q;
      rsp_cur_q   <= cur_q[tcce_pkg::ADDR_OUT_W-1:0];
      rsp_start_q <= start_q[tcce_pkg::ADDR_OUT_W-1:0];
      rsp_data_q  <= ((req_type_q == tcce_pkg::REQ_READ) && rd_ok) ? rd_q : '0;
    end
  end

  assign rsp_valid_o      = rsp_valid_q;
  assign accepted_o       = rsp_acc_q;
  assign cursor_address_o = rsp_cur_q;
  assign start_address_o  = rsp_start_q;
  assign read_data_o      = rsp_data_q;

endmodule

/* design/tcce_checker.sv */
// port-level checker for the console top, with its bind
`timescale 1ns / 1ps
`include "text_console_cursor_engine_top_macros.svh"
module tcce_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic                              rsp_accepted_i,
  input logic [tcce_pkg::ADDR_OUT_W-1:0]   rsp_cursor_address_i,
  input logic [tcce_pkg::ADDR_OUT_W-1:0]   rsp_start_address_i,
  input logic [tcce_pkg::DATA_W-1:0]       rsp_read_data_i,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic                              pready,
  input logic [tcce_pkg::PADDR_W-1:0]      paddr,
  input logic [tcce_pkg::APB_DATA_W-1:0]   pwdata,
  input logic [tcce_pkg::APB_DATA_W-1:0]   prdata
);

  logic                                                rsp_stall;
  logic [2*tcce_pkg::ADDR_OUT_W+tcce_pkg::DATA_W:0]    rsp_beat;
  logic                                                attr_we;
  logic [tcce_pkg::ATTR_W-1:0]                         rd_attr;
  logic [tcce_pkg::ATTR_W-1:0]                         wr_attr;

  assign rsp_stall = rsp_valid_i && !rsp_ready_i;
  assign rsp_beat  = {rsp_accepted_i, rsp_cursor_address_i, rsp_start_address_i,
                      rsp_read_data_i};
  assign attr_we   = psel && penable && pwrite && pready && !paddr[2];
  assign rd_attr   = prdata[tcce_pkg::ATTR_W-1:0];
  assign wr_attr   = pwdata[tcce_pkg::ATTR_W-1:0];

  // one request in flight: no second beat straight after an accepted one
  `TCCE_ASSERT_NEXT(a_one_in_flight, req_valid_i && req_ready_i, !req_ready_i, "request taken while busy")

  // a response cannot appear the cycle after its request beat
  `TCCE_ASSERT_NEXT(a_no_early_rsp, req_valid_i && req_ready_i, !$rose(rsp_valid_i), "response too early")

  // stalled response beat keeps its payload
  `TCCE_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid_i && $stable(rsp_beat), "stalled response changed")

  // attribute register reads back what was written
  `TCCE_ASSERT_NEXT(a_attr_readback, attr_we, paddr[2] || rd_attr == $past(wr_attr), "bad readback")

  // apb completes in the access cycle
  `TCCE_ASSERT_NOW(a_pready, psel && penable, pready, "pready low in access cycle")

endmodule

bind text_console_cursor_engine_top tcce_checker u_tcce_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req_i.valid),
  .req_ready_i          (req_i.ready),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_accepted_i       (rsp_o.accepted),
  .rsp_cursor_address_i (rsp_o.cursor_address),
  .rsp_start_address_i  (rsp_o.start_address),
  .rsp_read_data_i      (rsp_o.read_data),
  .psel                 (psel),
  .penable              (penable),
  .pwrite               (pwrite),
  .pready               (pready),
  .paddr                (paddr),
  .pwdata               (pwdata),
  .prdata               (prdata)
);

/* tb/tb_top.sv */
// self-checking testbench for the text console cursor engine
`timescale 1ns / 1ps
module tb_top;
  import tcce_pkg::*;

  localparam int COLS   = COLUMNS_DEF;
  localparam int ROWS_N = ROWS_DEF;
  localparam int CELLS  = BUFFER_CELLS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int MAX_PRINTS  = 200;
  localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [PADDR_W-1:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

  typedef struct {
    logic [REQ_TYPE_W-1:0] kind;
    logic [CHAR_W-1:0]     ch;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic [CELL_IDX_W-1:0] idx;
  } console_req_t;

  typedef struct {
    logic                  accepted;
    logic [ADDR_OUT_W-1:0] cursor_addr;
    logic [ADDR_OUT_W-1:0] start_addr;
    logic [DATA_W-1:0]     rdata;
  } console_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  tcce_req_if req_bus ();
  tcce_rsp_if rsp_bus ();

  text_console_cursor_engine_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the console state
  logic [DATA_W-1:0] shadow_cells [CELLS];
  bit                shadow_known [CELLS];
  int                cur_col = 0;
  int                cur_row = 0;
  int                win_top = 0;
  logic [ATTR_W-1:0] attr_q = ATTR_RESET;

  console_rsp_t console_rsp_q[$];

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int holdoff_left  = 0;
  int err_count     = 0;
  int idle_cycles   = 0;

  function automatic void store_cell(int idx, logic [DATA_W-1:0] value);
    if (idx < CELLS) begin
      shadow_cells[idx] = value;
      shadow_known[idx] = 1'b1;
    end
  endfunction

  function automatic void blank_row(int row);
    for (int c = 0; c < COLS; c++) store_cell(row * COLS + c, {ATTR_CLEAR, CHAR_SPACE});
  endfunction

  function automatic void scroll_up();
    int top_n;
    int base;
    top_n = win_top + 1;
    cur_row = ROWS_N - 1;
    if ((top_n + ROWS_N) * COLS <= CELLS) begin
      blank_row(top_n + ROWS_N - 1);
      win_top = top_n & 8'hff;
    end else begin
      // end of buffer: visible rows go back to the start
      base = top_n * COLS;
      for (int i = 0; i < (ROWS_N - 1) * COLS; i++) begin
        if (base + i < CELLS && i < CELLS) begin
          shadow_cells[i] = shadow_cells[base + i];
          shadow_known[i] = shadow_known[base + i];
        end
      end
      blank_row(ROWS_N - 1);
      win_top = 0;
    end
  endfunction

  function automatic void line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS_N) scroll_up();
  endfunction

  function automatic logic place_char(logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] c;
    c = ch;
    if (ch == CHAR_NEWLINE) begin
      line_feed();
      return 1'b1;
    end
    if (ch == CHAR_TAB) c = CHAR_SPACE;
    if (cur_col >= COLS || cur_row >= ROWS_N) return 1'b0;
    store_cell((cur_row + win_top) * COLS + cur_col, {attr_q, c});
    cur_col++;
    if (cur_col >= COLS) line_feed();
    return 1'b1;
  endfunction

  function automatic console_rsp_t console_step(console_req_t r);
    console_rsp_t o;
    o.accepted = 1'b0;
    o.rdata = '0;
    case (r.kind)
      REQ_PUT: o.accepted = place_char(r.ch);
      REQ_SET_POS: begin
        if (r.col < COLS && r.row < ROWS_N) begin
          cur_col = r.col;
          cur_row = r.row;
          o.accepted = 1'b1;
        end
      end
      REQ_READ: begin
        if (r.idx < CELLS) begin
          o.rdata = shadow_cells[r.idx];
          o.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    o.cursor_addr = ADDR_OUT_W'((cur_row + win_top) * COLS + cur_col);
    o.start_addr  = ADDR_OUT_W'(win_top * COLS);
    return o;
  endfunction

  // first written cell at or after start, wrapping round the buffer, -1 while nothing is written
  function automatic int find_known(int start);
    int j;
    for (int n = 0; n < CELLS; n++) begin
      j = (start + n) % CELLS;
      if (shadow_known[j]) return j;
    end
    return -1;
  endfunction

  function automatic console_req_t rand_fields(logic [REQ_TYPE_W-1:0] kind);
    console_req_t r;
    r.kind = kind;
    r.ch   = CHAR_W'($urandom);
    r.col  = COL_W'($urandom);
    r.row  = ROW_W'($urandom);
    r.idx  = CELL_IDX_W'($urandom);
    return r;
  endfunction

  function automatic console_req_t put_req(logic [CHAR_W-1:0] ch);
    console_req_t r;
    r = rand_fields(REQ_PUT);
    r.ch = ch;
    return r;
  endfunction

  function automatic console_req_t pos_req(int col, int row);
    console_req_t r;
    r = rand_fields(REQ_SET_POS);
    r.col = COL_W'(col);
    r.row = ROW_W'(row);
    return r;
  endfunction

  function automatic console_req_t read_req(int idx);
    console_req_t r;
    r = rand_fields(REQ_READ);
    r.idx = CELL_IDX_W'(idx);
    return r;
  endfunction

  function automatic console_req_t rand_req();
    console_req_t r;
    int pick;
    int j;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r = put_req(CHAR_W'($urandom));
    end else if (pick < 45) begin
      r = put_req(CHAR_NEWLINE);
    end else if (pick < 52) begin
      r = put_req(CHAR_TAB);
    end else if (pick < 67) begin
      // lean on the last column and bottom row to provoke wraps and scrolls
      r = pos_req(($urandom_range(0, 3) == 0) ? COLS - 1 : $urandom_range(0, COLS - 1),
                  $urandom_range(0, 1) ? ROWS_N - 1 : $urandom_range(0, ROWS_N - 1));
    end else if (pick < 72) begin
      r = rand_fields(REQ_SET_POS);
      if ($urandom_range(0, 1)) r.col = COL_W'($urandom_range(COLS, 127));
      else r.row = ROW_W'($urandom_range(ROWS_N, 31));
    end else if (pick < 95) begin
      j = find_known($urandom_range(0, CELLS - 1));
      if (j < 0) r = put_req(CHAR_W'($urandom));
      else r = read_req(j);
    end else begin
      r = rand_fields(REQ_UNKNOWN);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic send_req(input console_req_t r);
    @(negedge clk_i);
    while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid         <= 1'b1;
    req_bus.req_type      <= r.kind;
    req_bus.char_code     <= r.ch;
    req_bus.target_column <= r.col;
    req_bus.target_row    <= r.row;
    req_bus.cell_index    <= r.idx;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    console_rsp_q.push_back(console_step(r));
  endtask

  task automatic idle_req_line();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (console_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_attr(input logic [ATTR_W-1:0] value);
    wait_drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {{(APB_DATA_W - ATTR_W){1'b0}}, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    attr_q = value;
    // read back the same register
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[ATTR_W-1:0] !== value) report_mismatch("text_attribute readback",
                                                      prdata, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_req(put_req(8'h41));
    send_req(put_req(8'h00));
    send_req(put_req(8'hff));
    send_req(put_req(CHAR_TAB));
    send_req(read_req(0));
    send_req(read_req(3));
    // last column wraps to the next line
    send_req(pos_req(COLS - 1, 0));
    send_req(put_req(8'h7a));
    send_req(put_req(CHAR_NEWLINE));
    // newline on the bottom row scrolls and clears the new row
    send_req(pos_req(0, ROWS_N - 1));
    send_req(put_req(CHAR_NEWLINE));
    send_req(read_req(ROWS_N * COLS));
    // wrap on the bottom row scrolls as well
    send_req(pos_req(COLS - 1, ROWS_N - 1));
    send_req(put_req(8'h78));
    send_req(read_req(ROWS_N * COLS + COLS - 1));
    send_req(pos_req(COLS, 0));
    send_req(pos_req(127, 31));
    send_req(pos_req(0, ROWS_N));
    send_req(pos_req(COLS - 1, ROWS_N));
    send_req('{kind: REQ_UNKNOWN, ch: '1, col: '1, row: '1, idx: '1});
    send_req(pos_req(0, 0));
    send_req(put_req(CHAR_NEWLINE));
    idle_req_line();
    wait_drain();
  endtask

  task automatic test_random(input int src_pct, input int snk_pct, input int count);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int n = 0; n < count; n++) send_req(rand_req());
    idle_req_line();
    wait_drain();
  endtask

  // enough bottom-row newlines to run off the end of the buffer
  task automatic test_buffer_wrap();
    int j;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_req(pos_req($urandom_range(0, COLS - 1), ROWS_N - 1));
    for (int n = 0; n < 190; n++) begin
      if ($urandom_range(0, 1)) send_req(put_req(CHAR_W'($urandom)));
      if ($urandom_range(0, 9) == 0) begin
        j = find_known($urandom_range(0, CELLS - 1));
        if (j >= 0) send_req(read_req(j));
      end
      send_req(put_req(CHAR_NEWLINE));
    end
    idle_req_line();
    wait_drain();
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    @(posedge clk_i);
    holdoff_left = 400;
    for (int n = 0; n < 24; n++) send_req(rand_req());
    idle_req_line();
    wait_drain();
  endtask

  // receiver side of the response channel
  always @(negedge clk_i) begin
    if (holdoff_left > 0) begin
      holdoff_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    console_rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (console_rsp_q.size() == 0) begin
        report_mismatch("response beat with nothing expected", 0, 0);
      end else begin
        want = console_rsp_q.pop_front();
        if (rsp_bus.accepted !== want.accepted)
          report_mismatch("accepted", rsp_bus.accepted, want.accepted);
        if (rsp_bus.cursor_address !== want.cursor_addr)
          report_mismatch("cursor_address", rsp_bus.cursor_address, want.cursor_addr);
        if (rsp_bus.start_address !== want.start_addr)
          report_mismatch("start_address", rsp_bus.start_address, want.start_addr);
        if (rsp_bus.read_data !== want.rdata)
          report_mismatch("read_data", rsp_bus.read_data, want.rdata);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    req_bus.valid         = 1'b0;
    req_bus.req_type      = REQ_PUT;
    req_bus.char_code     = '0;
    req_bus.target_column = '0;
    req_bus.target_row    = '0;
    req_bus.cell_index    = '0;
    rsp_bus.ready         = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    set_attr(8'hff);
    test_random(0, 0, 290);
    set_attr(8'h00);
    test_random(62, 0, 290);
    set_attr(ATTR_W'($urandom));
    test_buffer_wrap();
    set_attr(ATTR_W'($urandom));
    test_random(0, 62, 290);
    test_backpressure();
    set_attr(ATTR_W'($urandom));
    test_random(12, 12, 290);

    wait_drain();
    repeat (40) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/tcce_pkg.sv
design/tcce_req_if.sv
design/tcce_rsp_if.sv
design/tcce_cfg_regs.sv
design/tcce_ctrl.sv
design/tcce_datapath.sv
design/text_console_cursor_engine_top.sv
design/tcce_checker.sv
tb/tb_top.sv
